[rtl/core/tcpu_pkg.sv]
// ----------------------------------------------------------------------------
// tcpu_pkg
// Shared types and codes of the teaching processor execute unit.
// ----------------------------------------------------------------------------
package tcpu_pkg;

    localparam logic [3:0] OP_ILLEGAL = 4'd0;
    localparam logic [3:0] OP_NOP     = 4'd1;
    localparam logic [3:0] OP_LOAD    = 4'd2;
    localparam logic [3:0] OP_STORE   = 4'd3;
    localparam logic [3:0] OP_ADD     = 4'd4;
    localparam logic [3:0] OP_SUB     = 4'd5;
    localparam logic [3:0] OP_BRANCH  = 4'd6;
    localparam logic [3:0] OP_CALL    = 4'd7;
    localparam logic [3:0] OP_RET     = 4'd8;
    localparam logic [3:0] OP_PUSH    = 4'd9;
    localparam logic [3:0] OP_POP     = 4'd10;
    localparam logic [3:0] OP_HALT    = 4'd11;

    localparam logic [3:0] ST_OK      = 4'd0;
    localparam logic [3:0] ST_HALT    = 4'd1;
    localparam logic [3:0] ST_ILLEGAL = 4'd2;
    localparam logic [3:0] ST_UNKNOWN = 4'd3;
    localparam logic [3:0] ST_COND    = 4'd4;
    localparam logic [3:0] ST_IMM     = 4'd5;
    localparam logic [3:0] ST_DATA    = 4'd6;
    localparam logic [3:0] ST_STACK   = 4'd7;
    localparam logic [3:0] ST_STOPPED = 4'd8;

    localparam logic [1:0] CC_UNSET = 2'd0;
    localparam logic [1:0] CC_ZERO  = 2'd1;
    localparam logic [1:0] CC_NEG   = 2'd2;
    localparam logic [1:0] CC_POS   = 2'd3;

    localparam logic CFG_DATA_SIZE = 1'b0;
    localparam logic CFG_DATA_END  = 1'b1;

    typedef struct packed {
        logic [3:0]  op;
        logic        is_immediate;
        logic        is_indexed;
        logic [3:0]  reg_or_cond;
        logic [15:0] imm_value;
        logic [15:0] abs_address;
        logic [3:0]  index_reg;
        logic [15:0] index_offset;
    } t_instr;

    typedef struct packed {
        logic [3:0]  status;
        logic [15:0] next_pc;
        logic [1:0]  cond_code;
    } t_result;

    typedef struct packed {
        logic [3:0]  index;
        logic [12:0] data;
    } t_cfg;

endpackage

[rtl/core/tcpu_if.sv]
// ----------------------------------------------------------------------------
// tcpu_if
// Valid/ready channel carrying one payload of a chosen type.
// ----------------------------------------------------------------------------
interface tcpu_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/teaching_cpu_execute_unit.sv]
// ----------------------------------------------------------------------------
// teaching_cpu_execute_unit
// Executes one decoded instruction per request against registers and memory.
// ----------------------------------------------------------------------------
// A taken request is registered, and the execute phase registers its result;
// no new request is taken meanwhile. The data store's single port reads at
// decode and writes at execute. A stalled result blocks the input; a request
// is taken as it leaves. Reset is synchronous, active low; it clears control
// state and the register file. The data store has no flip-flop per entry: after
// reset a clearing pass writes zero to every word while no request is accepted.
module teaching_cpu_execute_unit
    import tcpu_pkg::*;
#(
    parameter int REGISTER_COUNT = 16,
    parameter int DATA_WORDS     = 4096,
    parameter int WORD_BITS      = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    tcpu_if.sink   cfg,
    tcpu_if.sink   in_ch,
    tcpu_if.source out_ch
);
    localparam int AW = $clog2(DATA_WORDS);
    localparam int RW = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
    localparam logic [16:0] DW17 = 17'(DATA_WORDS);
    localparam logic [16:0] SP_RST = 17'(((DATA_WORDS < 4096) ? DATA_WORDS : 4096) - 1);

    logic [WORD_BITS-1:0] r_mem [DATA_WORDS];
    logic [WORD_BITS-1:0] r_rf  [REGISTER_COUNT];
    logic [WORD_BITS-1:0] r_rdata;

    logic [15:0] r_pc;
    logic [16:0] r_sp;
    logic [1:0]  r_cc;
    logic        r_stopped;
    logic [12:0] r_size;
    logic [12:0] r_dend;
    logic        r_clearing;
    logic [AW:0] r_clr_addr;

    // Phase 1 holds the decoded request while the memory read completes.
    logic        r_busy;
    t_instr      r_ins;
    logic [3:0]  r_st;        // status known at decode time
    logic [AW-1:0] r_waddr;
    logic        r_mem_rd;    // operand comes from memory
    logic        r_out_valid;
    t_result     r_out;

    // Effective size, saturated at the store depth.
    logic [16:0] eff;
    assign eff = ({4'd0, r_size} > DW17) ? DW17 : {4'd0, r_size};

    function automatic logic [WORD_BITS-1:0] sext(input logic [15:0] x);
        return WORD_BITS'($signed(x));
    endfunction

    function automatic logic stk_ok(input logic [16:0] p, input logic [16:0] e,
                                    input logic [12:0] de);
        return (p < e) && (p >= {4'd0, de});
    endfunction

    // Register number folded into the register count by repeated subtraction.
    function automatic logic [RW-1:0] reg_sel(input logic [3:0] x);
        logic [4:0] v;
        v = {1'b0, x};
        for (int k = 0; k < 4; k++) begin
            if (v >= 5'(REGISTER_COUNT)) v = v - 5'(REGISTER_COUNT);
        end
        return RW'(v);
    endfunction

    // Decode stage: address and fault checks against current state.
    t_instr i;
    logic [WORD_BITS-1:0] idx_sum;
    logic        daddr_ok;
    logic [16:0] daddr;
    logic [3:0]  st0;
    logic        cond_val, cond_bad;
    logic [16:0] spm1, spp1;
    logic [16:0] raddr;
    logic        rd_mem;
    logic [AW-1:0] waddr0;

    always_comb begin
        i = in_ch.payload;
        idx_sum = r_rf[reg_sel(i.index_reg)] + sext(i.index_offset);
        if (i.is_indexed) begin
            daddr_ok = !idx_sum[WORD_BITS-1] && (idx_sum < WORD_BITS'(eff));
            daddr = 17'(idx_sum[AW-1:0]);
        end else begin
            daddr_ok = {1'b0, i.abs_address} < eff;
            daddr = {1'b0, i.abs_address};
        end
        spm1 = r_sp - 17'd1;
        spp1 = r_sp + 17'd1;
        cond_bad = 1'b0;
        case (i.reg_or_cond)
            4'd0: cond_val = 1'b1;
            4'd1: cond_val = r_cc == CC_ZERO;
            4'd2: cond_val = r_cc != CC_ZERO;
            4'd3: cond_val = r_cc == CC_POS;
            4'd4: cond_val = r_cc != CC_NEG;
            4'd5: cond_val = r_cc == CC_NEG;
            4'd6: cond_val = r_cc != CC_POS;
            default: begin cond_val = 1'b0; cond_bad = 1'b1; end
        endcase
        st0 = ST_OK;
        raddr = daddr;
        rd_mem = 1'b0;
        waddr0 = daddr[AW-1:0];
        if (r_stopped) begin
            st0 = ST_STOPPED;
        end else begin
            case (i.op)
                OP_ILLEGAL: st0 = ST_ILLEGAL;
                OP_NOP: ;
                OP_LOAD, OP_ADD, OP_SUB: begin
                    if (!i.is_immediate) begin
                        if (!daddr_ok) st0 = ST_DATA;
                        else rd_mem = 1'b1;
                    end
                end
                OP_STORE: begin
                    if (i.is_immediate) st0 = ST_IMM;
                    else if (!daddr_ok) st0 = ST_DATA;
                end
                OP_BRANCH, OP_CALL: begin
                    waddr0 = r_sp[AW-1:0];
                    if (i.is_immediate) st0 = ST_IMM;
                    else if (cond_bad) st0 = ST_COND;
                    else if (cond_val) begin
                        if (i.op == OP_CALL && (!stk_ok(r_sp, eff, r_dend) ||
                                                !stk_ok(spm1, eff, r_dend)))
                            st0 = ST_STACK;
                        else if ({1'b0, i.abs_address} >= eff) st0 = ST_DATA;
                    end
                end
                OP_RET: begin
                    raddr = spp1;
                    if (!stk_ok(spp1, eff, r_dend)) st0 = ST_STACK;
                    else rd_mem = 1'b1;
                end
                OP_PUSH: begin
                    waddr0 = r_sp[AW-1:0];
                    if (!i.is_immediate && !daddr_ok) st0 = ST_DATA;
                    else if (!stk_ok(r_sp, eff, r_dend) || !stk_ok(spm1, eff, r_dend))
                        st0 = ST_STACK;
                    else rd_mem = !i.is_immediate;
                end
                OP_POP: begin
                    raddr = spp1;
                    if (i.is_immediate) st0 = ST_IMM;
                    else if (!daddr_ok) st0 = ST_DATA;
                    else if (!stk_ok(spp1, eff, r_dend)) st0 = ST_STACK;
                    else rd_mem = 1'b1;
                end
                OP_HALT: st0 = ST_HALT;
                default: st0 = ST_UNKNOWN;
            endcase
        end
    end

    logic accept;
    assign in_ch.ready  = !r_busy && !r_clearing && (!r_out_valid || out_ch.ready);
    assign accept       = in_ch.valid && in_ch.ready;
    assign cfg.ready    = 1'b1;
    assign out_ch.valid = r_out_valid;
    assign out_ch.payload = r_out;

    // Memory port: read in decode cycle, write in execute cycle.
    logic                 we;
    logic [AW-1:0]        wa;
    logic [WORD_BITS-1:0] wd;

    always_ff @(posedge i_clk) begin
        if (we) r_mem[wa] <= wd;
        else r_rdata <= r_mem[raddr[AW-1:0]];
    end

    // Execute stage.
    logic [WORD_BITS-1:0] opv, rv, res;
    logic [RW-1:0] rsel;
    logic [1:0]    ccn;
    logic [15:0]   npc;
    logic          rf_we;

    always_comb begin
        rsel = reg_sel(r_ins.reg_or_cond);
        rv   = r_rf[rsel];
        opv  = r_mem_rd ? r_rdata : sext(r_ins.imm_value);
        res  = (r_ins.op == OP_ADD) ? rv + opv :
               (r_ins.op == OP_SUB) ? rv - opv : opv;
        ccn  = (res == '0) ? CC_ZERO : (res[WORD_BITS-1] ? CC_NEG : CC_POS);
        npc  = r_pc + 16'd1;
        we   = 1'b0;
        wa   = r_waddr;
        wd   = rv;
        rf_we = 1'b0;
        if (r_clearing) begin
            we = 1'b1;
            wa = r_clr_addr[AW-1:0];
            wd = '0;
        end else if (r_busy && r_st == ST_OK) begin
            case (r_ins.op)
                OP_LOAD, OP_ADD, OP_SUB: rf_we = 1'b1;
                OP_STORE: we = 1'b1;
                OP_BRANCH, OP_CALL: begin
                    if (r_ins.reg_or_cond == 4'd0 || r_mem_rd) begin
                        if (r_ins.op == OP_CALL) begin
                            we = 1'b1;
                            wd = WORD_BITS'(npc);
                        end
                        npc = r_ins.abs_address;
                    end
                end
                OP_RET: npc = r_rdata[15:0];
                OP_PUSH: begin we = 1'b1; wd = opv; end
                OP_POP: begin we = 1'b1; wd = r_rdata; end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= '0;
            r_sp <= SP_RST;
            r_cc <= CC_UNSET;
            r_stopped <= 1'b0;
            r_size <= 13'd4096;
            r_dend <= '0;
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_busy <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < REGISTER_COUNT; k++) r_rf[k] <= '0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == (AW+1)'(DATA_WORDS - 1)) r_clearing <= 1'b0;
            end
            if (cfg.valid) begin
                if (cfg.payload.index == {3'd0, CFG_DATA_SIZE}) begin
                    r_size <= cfg.payload.data;
                    r_sp <= ((({4'd0, cfg.payload.data} > DW17) ? DW17
                             : {4'd0, cfg.payload.data}) - 17'd1);
                end else if (cfg.payload.index == {3'd0, CFG_DATA_END}) begin
                    r_dend <= cfg.payload.data;
                end
            end
            if (r_busy) r_out_valid <= 1'b1;
            else if (out_ch.ready) r_out_valid <= 1'b0;
            if (accept) begin
                r_busy <= 1'b1;
                r_ins <= i;
                r_st <= st0;
                r_waddr <= waddr0;
                // For branch and call the flag records whether it is taken.
                r_mem_rd <= (i.op == OP_BRANCH || i.op == OP_CALL) ? cond_val : rd_mem;
            end
            if (r_busy) begin
                r_busy <= 1'b0;
                r_out.status <= r_st;
                r_out.next_pc <= (r_st == ST_OK) ? npc : r_pc;
                r_out.cond_code <= rf_we ? ccn : r_cc;
                if (r_st == ST_STOPPED) begin
                end else if (r_st != ST_OK) begin
                    r_stopped <= 1'b1;
                end else begin
                    r_pc <= npc;
                    if (rf_we) begin
                        r_rf[rsel] <= res;
                        r_cc <= ccn;
                    end
                    if ((r_ins.op == OP_CALL && we) || r_ins.op == OP_PUSH)
                        r_sp <= r_sp - 17'd1;
                    if (r_ins.op == OP_RET || r_ins.op == OP_POP)
                        r_sp <= r_sp + 17'd1;
                end
            end
        end
    end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the teaching processor execute unit. A predictor
// runs every accepted request and the output channel is checked against it.
// ----------------------------------------------------------------------------

module tb
    import tcpu_pkg::*;
();

class exec_scoreboard;

    logic [31:0] regs [16];
    logic [31:0] mem [4096];
    logic [15:0] pc;
    logic [16:0] sp;
    logic [1:0]  cc;
    bit          stopped;
    logic [12:0] dsize;
    logic [12:0] dend;
    t_result     pending [$];
    int          mismatches;
    int          checked;
    int          status_seen [9];

    function void clear();
        foreach (regs[k]) regs[k] = '0;
        foreach (mem[k]) mem[k] = '0;
        pc = '0;
        dsize = 13'd4096;
        dend = '0;
        sp = 17'(eff_size() - 1);
        cc = CC_UNSET;
        stopped = 0;
        mismatches = 0;
        checked = 0;
    endfunction

    function int eff_size();
        return (dsize > 13'd4096) ? 4096 : int'(dsize);
    endfunction

    function void write_reg(logic [3:0] idx, logic [12:0] val);
        if (idx == 4'(CFG_DATA_SIZE)) begin
            dsize = val;
            sp = 17'(eff_size() - 1);
        end else if (idx == 4'(CFG_DATA_END)) begin
            dend = val;
        end
    endfunction

    function logic [31:0] sext(logic [15:0] x);
        return {{16{x[15]}}, x};
    endfunction

    function bit stack_ok(logic [16:0] p);
        return int'(p) < eff_size() && int'(p) >= int'(dend);
    endfunction

    function bit addr_ok(t_instr ins, output int a);
        logic [31:0] s;
        a = 0;
        if (ins.is_indexed) begin
            s = regs[ins.index_reg] + sext(ins.index_offset);
            if (s[31] || s >= 32'(eff_size())) return 0;
            a = int'(s);
            return 1;
        end
        if (int'(ins.abs_address) >= eff_size()) return 0;
        a = int'(ins.abs_address);
        return 1;
    endfunction

    // 0 false, 1 true, 2 invalid condition
    function int cond_eval(logic [3:0] c);
        case (c)
            4'd0: return 1;
            4'd1: return int'(cc == CC_ZERO);
            4'd2: return int'(cc != CC_ZERO);
            4'd3: return int'(cc == CC_POS);
            4'd4: return int'(cc != CC_NEG);
            4'd5: return int'(cc == CC_NEG);
            4'd6: return int'(cc != CC_POS);
            default: return 2;
        endcase
    endfunction

    // Runs one instruction; state changes only when commit is set.
    function t_result execute(t_instr ins, bit commit);
        t_result     res;
        logic [3:0]  st;
        logic [15:0] np;
        logic [31:0] v;
        logic [31:0] wval;
        logic [16:0] nsp;
        logic [16:0] new_sp;
        logic [1:0]  new_cc;
        int          a;
        int          waddr;
        int          c;
        bit          wr_reg;
        bit          wr_mem;
        st = ST_OK;
        np = pc + 16'd1;
        v = '0;
        wval = '0;
        new_sp = sp;
        new_cc = cc;
        waddr = 0;
        wr_reg = 0;
        wr_mem = 0;
        if (stopped) begin
            st = ST_STOPPED;
        end else begin
            case (ins.op)
                OP_ILLEGAL: st = ST_ILLEGAL;
                OP_NOP: ;
                OP_LOAD, OP_ADD, OP_SUB: begin
                    if (ins.is_immediate) v = sext(ins.imm_value);
                    else if (!addr_ok(ins, a)) st = ST_DATA;
                    else v = mem[a];
                    if (st == ST_OK) begin
                        if (ins.op == OP_ADD) v = regs[ins.reg_or_cond] + v;
                        else if (ins.op == OP_SUB) v = regs[ins.reg_or_cond] - v;
                        wr_reg = 1;
                        new_cc = (v == 0) ? CC_ZERO : (v[31] ? CC_NEG : CC_POS);
                    end
                end
                OP_STORE: begin
                    if (ins.is_immediate) st = ST_IMM;
                    else if (!addr_ok(ins, a)) st = ST_DATA;
                    else begin
                        wr_mem = 1;
                        waddr = a;
                        wval = regs[ins.reg_or_cond];
                    end
                end
                OP_BRANCH, OP_CALL: begin
                    c = cond_eval(ins.reg_or_cond);
                    nsp = sp - 17'd1;
                    if (ins.is_immediate) st = ST_IMM;
                    else if (c == 2) st = ST_COND;
                    else if (c == 1) begin
                        if (ins.op == OP_CALL && (!stack_ok(sp) || !stack_ok(nsp)))
                            st = ST_STACK;
                        else if (int'(ins.abs_address) >= eff_size()) st = ST_DATA;
                        else begin
                            if (ins.op == OP_CALL) begin
                                wr_mem = 1;
                                waddr = int'(sp);
                                wval = {16'd0, np};
                                new_sp = nsp;
                            end
                            np = ins.abs_address;
                        end
                    end
                end
                OP_RET: begin
                    nsp = sp + 17'd1;
                    if (!stack_ok(nsp)) st = ST_STACK;
                    else begin
                        new_sp = nsp;
                        np = mem[nsp][15:0];
                    end
                end
                OP_PUSH: begin
                    nsp = sp - 17'd1;
                    if (ins.is_immediate) v = sext(ins.imm_value);
                    else if (!addr_ok(ins, a)) st = ST_DATA;
                    else v = mem[a];
                    if (st == ST_OK) begin
                        if (!stack_ok(sp) || !stack_ok(nsp)) st = ST_STACK;
                        else begin
                            wr_mem = 1;
                            waddr = int'(sp);
                            wval = v;
                            new_sp = nsp;
                        end
                    end
                end
                OP_POP: begin
                    nsp = sp + 17'd1;
                    if (ins.is_immediate) st = ST_IMM;
                    else if (!addr_ok(ins, a)) st = ST_DATA;
                    else if (!stack_ok(nsp)) st = ST_STACK;
                    else begin
                        wr_mem = 1;
                        waddr = a;
                        wval = mem[nsp];
                        new_sp = nsp;
                    end
                end
                OP_HALT: st = ST_HALT;
                default: st = ST_UNKNOWN;
            endcase
        end
        if (commit && !stopped) begin
            if (st != ST_OK) begin
                stopped = 1;
            end else begin
                if (wr_reg) regs[ins.reg_or_cond] = v;
                if (wr_mem) mem[waddr] = wval;
                sp = new_sp;
                cc = new_cc;
                pc = np;
            end
        end
        res.status = st;
        res.next_pc = (commit || st != ST_OK) ? pc : np;
        res.cond_code = commit ? cc : new_cc;
        return res;
    endfunction

    function void note_request(t_instr ins);
        t_result r;
        r = execute(ins, 1);
        pending.push_back(r);
        if (r.status <= ST_STOPPED) status_seen[r.status]++;
    endfunction

    function void check_result(t_result got);
        t_result want;
        checked++;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: status %0d pc %h cc %0d",
                         got.status, got.next_pc, got.cond_code);
            return;
        end
        want = pending.pop_front();
        if (got.status !== want.status || got.next_pc !== want.next_pc ||
            got.cond_code !== want.cond_code) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d mismatch: status %0d/%0d pc %h/%h cc %0d/%0d",
                         checked, want.status, got.status, want.next_pc, got.next_pc,
                         want.cond_code, got.cond_code);
        end
    endfunction
endclass

    localparam int CYCLE_LIMIT = 600000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    int   cycles = 0;
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    int   sent = 0;

    tcpu_if #(.T(t_cfg))    cfg ();
    tcpu_if #(.T(t_instr))  in_ch ();
    tcpu_if #(.T(t_result)) out_ch ();

    exec_scoreboard exec_sb = new();

    teaching_cpu_execute_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .cfg     (cfg),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    always #10 i_clk = ~i_clk;

    initial begin
        cfg.valid = 0;
        cfg.payload = '0;
        in_ch.valid = 0;
        in_ch.payload = '0;
        out_ch.ready = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) exec_sb.check_result(out_ch.payload);
    end

    // The input is released first so that the last request is not taken again.
    task automatic wait_idle();
        in_ch.valid <= 0;
        while (exec_sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [3:0] idx, logic [12:0] val);
        wait_idle();
        cfg.valid <= 1;
        cfg.payload <= '{index: idx, data: val};
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
        cfg.valid <= 0;
        exec_sb.write_reg(idx, val);
    endtask

    task automatic send(t_instr ins);
        if ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_ch.valid <= 1;
        in_ch.payload <= ins;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        exec_sb.note_request(ins);
        sent++;
    endtask

    function automatic t_instr mk(logic [3:0] op, logic imm, logic idx, logic [3:0] rc,
                                  logic [15:0] iv, logic [15:0] ab, logic [3:0] ir,
                                  logic [15:0] io);
        t_instr ins;
        ins = '{op: op, is_immediate: imm, is_indexed: idx, reg_or_cond: rc,
                imm_value: iv, abs_address: ab, index_reg: ir, index_offset: io};
        return ins;
    endfunction

    function automatic t_instr random_instr();
        t_instr ins;
        ins = $bits(t_instr)'({$urandom, $urandom});
        return ins;
    endfunction

    // Builds an instruction that the current state executes without a fault.
    function automatic t_instr legal_instr();
        t_instr ins;
        int eff;
        int target;
        logic [31:0] diff;
        eff = exec_sb.eff_size();
        for (int tries = 0; tries < 60; tries++) begin
            ins = random_instr();
            ins.op = 4'($urandom_range(1, 10));
            if (ins.op inside {OP_STORE, OP_BRANCH, OP_CALL, OP_POP} && $urandom_range(7) != 0)
                ins.is_immediate = 0;
            if (ins.op inside {OP_BRANCH, OP_CALL}) ins.reg_or_cond = 4'($urandom_range(0, 6));
            if (eff > 0 && $urandom_range(7) != 0) begin
                target = $urandom_range(0, eff - 1);
                ins.abs_address = 16'(target);
                diff = 32'(target) - exec_sb.regs[ins.index_reg];
                if ($signed(diff) >= -32768 && $signed(diff) <= 32767)
                    ins.index_offset = diff[15:0];
            end
            if (exec_sb.execute(ins, 0).status == ST_OK) return ins;
        end
        ins.op = OP_NOP;
        return ins;
    endfunction

    task automatic run_phase(int count);
        for (int k = 0; k < count; k++) begin
            if (sent < 400) begin
                tx_idle_pct = 19;
                rx_idle_pct = 83;
            end else if (sent < 800) begin
                tx_idle_pct = 83;
                rx_idle_pct = 19;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            send(legal_instr());
        end
    endtask

    initial begin
        t_instr ins;
        int tries;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        exec_sb.clear();
        tx_idle_pct = 19;
        rx_idle_pct = 83;

        // Directed part at the reset configuration: extremes, every mode and condition.
        send(mk(OP_NOP, 0, 0, 0, 0, 0, 0, 0));
        send(mk(OP_LOAD, 1, 0, 1, 16'h8000, 0, 0, 0));
        send(mk(OP_ADD, 1, 0, 1, 16'h7FFF, 0, 0, 0));
        send(mk(OP_LOAD, 1, 0, 2, 16'h0000, 0, 0, 0));
        send(mk(OP_SUB, 1, 0, 3, 16'h0001, 0, 0, 0));
        send(mk(OP_LOAD, 1, 0, 15, 16'h7FFF, 0, 0, 0));
        send(mk(OP_STORE, 0, 0, 15, 0, 16'd4095, 0, 0));
        send(mk(OP_LOAD, 0, 0, 4, 0, 16'd4095, 0, 0));
        send(mk(OP_STORE, 0, 1, 1, 0, 16'hFFFF, 2, 16'd100));
        send(mk(OP_LOAD, 0, 1, 5, 0, 16'hFFFF, 15, -16'sd32667));
        send(mk(OP_PUSH, 1, 0, 0, 16'h1234, 0, 0, 0));
        send(mk(OP_POP, 0, 1, 0, 0, 0, 2, 16'd200));
        send(mk(OP_LOAD, 0, 0, 6, 0, 16'd100, 0, 0));
        send(mk(OP_BRANCH, 0, 0, 0, 0, 16'd10, 0, 0));
        send(mk(OP_BRANCH, 0, 0, 1, 0, 16'hFFFF, 0, 0));
        for (int c = 2; c <= 6; c++) send(mk(OP_BRANCH, 0, 0, 4'(c), 0, 16'(20 + c), 0, 0));
        send(mk(OP_CALL, 0, 0, 0, 0, 16'd50, 0, 0));
        send(mk(OP_RET, 1, 1, 0, 0, 0, 0, 0));
        send(mk(OP_SUB, 0, 0, 6, 0, 16'd100, 0, 0));
        send(mk(OP_ADD, 0, 1, 7, 0, 0, 2, 16'h0FFF));

        run_phase(160);
        write_cfg(4'(CFG_DATA_SIZE), 13'd64);
        write_cfg(4'(CFG_DATA_END), 13'd8);
        run_phase(200);
        write_cfg(4'(CFG_DATA_SIZE), 13'h1FFF);
        write_cfg(4'(CFG_DATA_END), 13'd4096);
        run_phase(180);
        write_cfg(4'(CFG_DATA_SIZE), 13'd1);
        write_cfg(4'(CFG_DATA_END), 13'd0);
        run_phase(120);
        write_cfg(4'(CFG_DATA_SIZE), 13'd0);
        run_phase(80);
        write_cfg(4'(CFG_DATA_SIZE), 13'd300);
        write_cfg(4'(CFG_DATA_END), 13'd100);
        run_phase(200);
        write_cfg(4'(CFG_DATA_SIZE), 13'd4096);
        write_cfg(4'(CFG_DATA_END), 13'h1FFF);
        write_cfg(4'(CFG_DATA_END), 13'd0);
        run_phase(200);

        // A fault stops the block for good, so one random fault closes the run.
        tries = 0;
        ins = random_instr();
        while (exec_sb.execute(ins, 0).status == ST_OK && tries < 1000) begin
            ins = random_instr();
            tries++;
        end
        send(ins);
        for (int k = 0; k < 6; k++) send(random_instr());
        in_ch.valid <= 0;

        while (exec_sb.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        $display("%0d requests, %0d results checked, %0d mismatches", sent,
                 exec_sb.checked, exec_sb.mismatches);
        $display("ok %0d, closing opcode %0d, stopped replies %0d", exec_sb.status_seen[0],
                 ins.op, exec_sb.status_seen[8]);
        if (exec_sb.mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

[sim.f]
rtl/core/tcpu_pkg.sv
rtl/core/tcpu_if.sv
rtl/core/teaching_cpu_execute_unit.sv
bench/tb.sv
